// File: rtl/core/sm3_block_compression_assert.svh
// assertion macros used by the sm3 block compression checker
`ifndef SM3_BLOCK_COMPRESSION_ASSERT_SVH
`define SM3_BLOCK_COMPRESSION_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm3 assertion failed");

// next-cycle implication checked outside reset
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm3 assertion failed");

`endif

// File: rtl/core/sm3_pkg.sv
// shared types, constants and functions of the sm3 compression block
`default_nettype none
package sm3_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned NumRounds   = 64;
   localparam int unsigned WindowDepth = 16;

   localparam logic [WordWidth-1:0] TjLow  = 32'h79CC4519;
   localparam logic [WordWidth-1:0] TjHigh = 32'h7A879D8A;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic {
      REQ_CHAIN = 1'b0,
      REQ_MSG   = 1'b1
   } req_kind_type;

   // control from sequencer to round unit
   typedef struct packed {
      logic       load;   // load working registers from chaining value
      logic       step;   // run one round
      logic [5:0] round;  // round index
   } round_ctrl_type;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [2*WordWidth-1:0] dbl;
      dbl = {x, x} << n;
      return dbl[2*WordWidth-1:WordWidth];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/sm3_msg_sched.sv
// message expansion window: 16-word shift line producing w[j] and w[j+4]
`default_nettype none
module sm3_msg_sched (
   input  wire                  clock,
   input  wire                  load,      // shift in a received message word
   input  wire                  advance,   // step window by one expanded word
   input  wire sm3_pkg::word_type load_word,
   output sm3_pkg::word_type     w_j,
   output sm3_pkg::word_type     w_j4
);
   import sm3_pkg::*;

   word_type win_ff [WindowDepth];
   word_type win_in [WindowDepth];
   word_type new_word;

   // w[j+16] from w[j], w[j+3], w[j+7], w[j+10], w[j+13]
   assign new_word = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
                     ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   assign w_j  = win_ff[0];
   assign w_j4 = win_ff[4];

   always_comb begin
      for (int i = 0; i < WindowDepth; i++) win_in[i] = win_ff[i];
      if (load || advance) begin
         for (int i = 0; i < WindowDepth - 1; i++) win_in[i] = win_ff[i+1];
         win_in[WindowDepth-1] = load ? load_word : new_word;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WindowDepth; i++) win_ff[i] <= win_in[i];
   end
endmodule
`default_nettype wire

// File: rtl/core/sm3_round.sv
// shared round unit holding working registers a..h
`default_nettype none
module sm3_round (
   input  wire                       clock,
   input  wire                       reset,
   input  wire sm3_pkg::round_ctrl_type ctrl,
   input  wire sm3_pkg::word_type    w_j,
   input  wire sm3_pkg::word_type    w_j4,
   input  wire sm3_pkg::word_type    chain [8],
   output sm3_pkg::word_type         work [8]
);
   import sm3_pkg::*;

   word_type work_ff [8];
   word_type work_in [8];
   word_type tj, a12, ss1, ss2, ff, gg, tt1, tt2;
   logic     early;

   assign early = (ctrl.round < 6'd16);
   assign tj    = early ? TjLow : TjHigh;
   assign a12   = rotl(work_ff[0], 5'd12);
   assign ss1   = rotl(a12 + work_ff[4] + rotl(tj, ctrl.round[4:0]), 5'd7);
   assign ss2   = ss1 ^ a12;
   assign ff    = early ? (work_ff[0] ^ work_ff[1] ^ work_ff[2])
                        : ((work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
                           | (work_ff[1] & work_ff[2]));
   assign gg    = early ? (work_ff[4] ^ work_ff[5] ^ work_ff[6])
                        : ((work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]));
   assign tt1   = ff + work_ff[3] + ss2 + (w_j ^ w_j4);
   assign tt2   = gg + work_ff[7] + ss1 + w_j;

   always_comb begin
      for (int i = 0; i < 8; i++) work_in[i] = work_ff[i];
      if (ctrl.load) begin
         for (int i = 0; i < 8; i++) work_in[i] = chain[i];
      end else if (ctrl.step) begin
         work_in[0] = tt1;
         work_in[1] = work_ff[0];
         work_in[2] = rotl(work_ff[1], 5'd9);
         work_in[3] = work_ff[2];
         work_in[4] = perm0(tt2);
         work_in[5] = work_ff[4];
         work_in[6] = rotl(work_ff[5], 5'd19);
         work_in[7] = work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= '0;
      end else begin
         for (int i = 0; i < 8; i++) work_ff[i] <= work_in[i];
      end
   end

   assign work = work_ff;
endmodule
`default_nettype wire

// File: rtl/core/sm3_block_compression.sv
// top level of the sm3 compression block
// sm3 compression of one 512-bit block per sixteen message requests. a request
// with tuser=0 writes chaining word chain_slot (A..H); a request with tuser=1
// shifts in one big-endian message word. the sixteenth message word starts a
// compression: a load step, 64 rounds at one round per cycle in the shared
// round unit (message expansion runs alongside in the 16-word window), then a
// feed-forward step, and then the eight new chaining words leave on the rsp
// port, A first, H marked with tlast. no request is taken from the sixteenth
// word until the last result word has been accepted; the chaining value stays
// across blocks.
`default_nettype none
module sm3_block_compression (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // chain_slot[2:0], data_word[34:3], zero pad
   input  wire         req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_position[34:32], zero pad
   output logic        rsp_tlast    // last_word
);
   import sm3_pkg::*;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_ROUNDS,
      ST_EMIT
   } state_type;

   state_type      state_ff, state_in;
   logic [3:0]     count_ff, count_in;   // message words received
   logic [5:0]     round_ff, round_in;
   logic [2:0]     pos_ff, pos_in;       // result word index
   logic           fold_ff, fold_in;     // feed-forward pending
   word_type       chain_ff [8];
   word_type       chain_in [8];
   word_type       work [8];
   word_type       w_j, w_j4;
   round_ctrl_type ctrl;
   logic           req_fire, msg_fire;
   logic [2:0]     slot;
   word_type       data;

   assign slot     = req_tdata[2:0];
   assign data     = req_tdata[34:3];
   assign req_fire = req_tvalid && req_tready;
   assign msg_fire = req_fire && (req_tuser == REQ_MSG);
   assign req_tready = (state_ff == ST_COLLECT);

   assign ctrl.load  = (state_ff == ST_LOAD);
   assign ctrl.step  = (state_ff == ST_ROUNDS);
   assign ctrl.round = round_ff;

   sm3_msg_sched u_sched (
      .clock     (clock),
      .load      (msg_fire),
      .advance   (ctrl.step),
      .load_word (data),
      .w_j       (w_j),
      .w_j4      (w_j4)
   );

   sm3_round u_round (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .w_j   (w_j),
      .w_j4  (w_j4),
      .chain (chain_ff),
      .work  (work)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      pos_in   = pos_ff;
      fold_in  = 1'b0;
      for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire && req_tuser == REQ_CHAIN) begin
               chain_in[slot] = data;
            end
            if (msg_fire) begin
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd15) state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            round_in = '0;
            state_in = ST_ROUNDS;
         end
         ST_ROUNDS: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               fold_in  = 1'b1;
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // feed-forward happens on the first cycle of this state
            if (fold_ff) begin
               for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] ^ work[i];
            end else if (rsp_tready) begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd7) state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         round_ff <= '0;
         pos_ff   <= '0;
         fold_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         pos_ff   <= pos_in;
         fold_ff  <= fold_in;
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
      end
   end

   assign rsp_tvalid = (state_ff == ST_EMIT) && !fold_ff;
   assign rsp_tdata  = {5'd0, pos_ff, chain_ff[pos_ff]};
   assign rsp_tlast  = (pos_ff == 3'd7);
endmodule
`default_nettype wire

// File: rtl/core/sm3_block_compression_checker.sv
// port-level checker for the sm3 compression block, with its bind
`default_nettype none
`include "sm3_block_compression_assert.svh"
module sm3_block_compression_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire        rsp_tlast
);
   // busy block never takes requests while results are offered
   `SM3_ASSERT_IMPL(no_req_during_rsp, clock, reset, rsp_tvalid, !req_tready)
   // tlast marks position H
   `SM3_ASSERT_IMPL(last_is_h, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd7))
   // stalled result holds
   `SM3_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   // after the final word the block accepts requests again
   `SM3_ASSERT_NEXT(ready_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                    req_tready)
endmodule

bind sm3_block_compression sm3_block_compression_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// File: tb/testbench.sv
// testbench of the sm3 block compression: predicted chaining words checked per response
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sm3_pkg::*;

   localparam int unsigned LatencyCycles = 80;
   localparam int unsigned WatchdogLimit = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // chain_slot[2:0], data_word[34:3], zero pad
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // digest_word[31:0], word_position[34:32], zero pad
   logic        rsp_tlast;   // last_word

   sm3_block_compression dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  position;
      logic        last;
   } digest_word_type;

   // predictor state
   logic [31:0] chain_model [8];
   logic [31:0] window_model [16];
   int unsigned msg_count;
   digest_word_type digest_queue [$];

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   bit          hold_off;
   int unsigned failures;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
      return (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - n % 32)));
   endfunction

   function automatic logic [31:0] mix0(input logic [31:0] x);
      return x ^ rot_left(x, 9) ^ rot_left(x, 17);
   endfunction

   function automatic logic [31:0] mix1(input logic [31:0] x);
      return x ^ rot_left(x, 15) ^ rot_left(x, 23);
   endfunction

   // full compression of the collected window into the chaining value
   task automatic compress_window();
      logic [31:0] w [68];
      logic [31:0] r [8];
      logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++) w[j] = window_model[j];
      for (int j = 16; j < 68; j++)
         w[j] = mix1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
                ^ rot_left(w[j-13], 7) ^ w[j-6];
      for (int k = 0; k < 8; k++) r[k] = chain_model[k];
      for (int j = 0; j < 64; j++) begin
         t   = (j < 16) ? TjLow : TjHigh;
         a12 = rot_left(r[0], 12);
         ss1 = rot_left(a12 + r[4] + rot_left(t, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = r[0] ^ r[1] ^ r[2];
            gg = r[4] ^ r[5] ^ r[6];
         end else begin
            ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            gg = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + r[7] + ss1 + w[j];
         r[3] = r[2]; r[2] = rot_left(r[1], 9); r[1] = r[0]; r[0] = tt1;
         r[7] = r[6]; r[6] = rot_left(r[5], 19); r[5] = r[4]; r[4] = mix0(tt2);
      end
      for (int k = 0; k < 8; k++) begin
         chain_model[k] = chain_model[k] ^ r[k];
         digest_queue.push_back('{chain_model[k], 3'(k), k == 7});
      end
   endtask

   // predict one accepted request
   task automatic predict_request(input req_kind_type kind, input logic [2:0] slot,
                                  input logic [31:0] data);
      if (kind == REQ_CHAIN) begin
         chain_model[slot] = data;
      end else begin
         window_model[msg_count] = data;
         msg_count++;
         if (msg_count == 16) begin
            msg_count = 0;
            compress_window();
         end
      end
   endtask

   // offer one request, with random idle beforehand, until accepted
   // valid stays up afterwards so the next request can follow back to back
   task automatic send_request(input req_kind_type kind, input logic [2:0] slot,
                               input logic [31:0] data);
      bit pause;
      pause = ($urandom_range(99) < send_idle_pct);
      if (pause) begin
         req_tvalid <= 1'b0;
         while (pause) begin
            @(negedge clock);
            pause = ($urandom_range(99) < send_idle_pct);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, data, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(kind, slot, data);
      @(negedge clock);
   endtask

   // drop valid once no further request follows
   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   task automatic send_block(input bit random_words);
      for (int i = 0; i < 16; i++)
         send_request(REQ_MSG, 3'($urandom), random_words ? $urandom : 32'(i));
   endtask

   task automatic wait_drained();
      while (digest_queue.size() != 0) @(negedge clock);
      repeat (LatencyCycles) @(negedge clock);
   endtask

   // response receiver with random stall
   always @(negedge clock) begin
      rsp_tready <= !hold_off && !reset && ($urandom_range(99) >= stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      digest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            failures++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== want.digest) begin
               $error("digest_word expected %h got %h", want.digest, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[34:32] !== want.position) begin
               $error("word_position expected %0d got %0d", want.position,
                      rsp_tdata[34:32]);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_word expected %b got %b", want.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // directed: standard test vector "abc", extremes of chaining words and slots
   task automatic test_directed();
      logic [31:0] iv [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                               32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
      for (int k = 0; k < 8; k++) send_request(REQ_CHAIN, 3'(k), iv[k]);
      send_request(REQ_MSG, 3'd7, 32'h61626380);
      for (int i = 1; i < 15; i++) send_request(REQ_MSG, 3'd0, 32'h0);
      send_request(REQ_MSG, 3'd5, 32'h00000018);
      // all-ones chaining and message, chaining write mid-block
      for (int k = 0; k < 8; k++) send_request(REQ_CHAIN, 3'(k), 32'hffffffff);
      for (int i = 0; i < 16; i++) begin
         if (i == 8) send_request(REQ_CHAIN, 3'd3, 32'h0);
         send_request(REQ_MSG, 3'd7, 32'hffffffff);
      end
   endtask

   // random mix of blocks, chaining writes, under one idle and stall setting
   task automatic test_random(input int unsigned requests, input int unsigned idle_pct,
                              input int unsigned stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int n = 0; n < requests; n++) begin
         if ($urandom_range(9) == 0)
            send_request(REQ_CHAIN, 3'($urandom), $urandom);
         else
            send_request(REQ_MSG, 3'($urandom), $urandom);
      end
   endtask

   // receiver holds off while requests keep coming, then sender waits for drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            send_block(1'b1);
            send_block(1'b1);
            stop_requests();
         end
      join
      wait_drained();
      send_block(1'b0);
      stop_requests();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      hold_off      = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      failures      = 0;
      msg_count     = 0;
      foreach (chain_model[k]) chain_model[k] = '0;
      foreach (window_model[k]) window_model[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(75, 0, 0);
      test_random(75, 88, 0);
      test_random(75, 0, 88);
      test_random(75, 20, 20);
      test_backpressure();
      wait_drained();

      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/sm3_pkg.sv
rtl/core/sm3_msg_sched.sv
rtl/core/sm3_round.sv
rtl/core/sm3_block_compression.sv
rtl/core/sm3_block_compression_checker.sv
tb/testbench.sv
